// ----- src/xce_pkg.sv -----
// Shared types, opcodes and defaults for the x86 code emitter with label fixups.
package xce_pkg;

  localparam int CODE_BYTES_DEF  = 1048576;
  localparam int LABEL_COUNT_DEF = 64;
  localparam int FIXUP_SLOTS_DEF = 32;

  localparam int ADDR_W   = 20;
  localparam int BUF_LEN  = 12;

  // x86 encoding bytes
  localparam logic [7:0] OP_REX_W    = 8'h48;
  localparam logic [7:0] MODRM_REG   = 8'hC0;
  localparam logic [7:0] OP_ESC      = 8'h0F;
  localparam logic [7:0] CC_JE       = 8'h84;
  localparam logic [7:0] CC_JLE      = 8'h8E;
  localparam logic [7:0] CC_JNE      = 8'h85;
  localparam logic [7:0] OP_JMP      = 8'hE9;
  localparam logic [7:0] OP_MOV_IMM  = 8'hB8;
  localparam logic [7:0] SIB_ESP     = 8'h24;
  localparam logic [7:0] OP_ALU_I32  = 8'h81;
  localparam logic [7:0] OP_ALU_I8   = 8'h80;
  localparam logic [7:0] MODRM_CALL  = 8'hD0;
  localparam logic [7:0] OP_GRP5     = 8'hFF;
  localparam logic [7:0] MODRM_CMP8  = 8'h38;
  localparam logic [7:0] OP_ADD_ACC  = 8'h05;
  localparam logic [7:0] OP_AND_ACC  = 8'h25;
  localparam logic [7:0] OP_CMP_ACC  = 8'h3D;
  localparam logic [7:0] OP_SUB_ACC  = 8'h2D;
  localparam logic [7:0] EXT_ADD     = 8'hC0;
  localparam logic [7:0] EXT_AND     = 8'hE0;
  localparam logic [7:0] EXT_CMP     = 8'hF8;
  localparam logic [7:0] EXT_SUB     = 8'hE8;
  localparam logic [7:0] OP_CMP_RR   = 8'h39;
  localparam logic [7:0] OP_MOV_RR   = 8'h8B;
  localparam logic [7:0] OP_XOR_RR   = 8'h31;
  localparam logic [7:0] OP_LEAVE    = 8'hC9;
  localparam logic [7:0] OP_MOV_LD8  = 8'h8A;
  localparam logic [7:0] OP_MOV_ST8  = 8'h88;
  localparam logic [7:0] OP_MOV_ST32 = 8'h89;
  localparam logic [7:0] OP_POP      = 8'h58;
  localparam logic [7:0] OP_PUSH     = 8'h50;
  localparam logic [7:0] OP_RET      = 8'hC3;

  // error codes
  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_SPACE  = 2'd1;
  localparam logic [1:0] ERR_PLACED = 2'd2;
  localparam logic [1:0] ERR_FIXUP  = 2'd3;

  typedef enum logic [4:0] {
    RQ_ADD_M8, RQ_ADD_I32, RQ_AND_I32, RQ_CALL, RQ_CMP_M8, RQ_CMP_I32, RQ_CMP_RR,
    RQ_JE, RQ_JLE, RQ_JMP, RQ_JNE, RQ_LEAVE, RQ_MOV_LD8, RQ_MOV_ST8, RQ_MOV_RR,
    RQ_MOV_IMM, RQ_MOV_ST32, RQ_POP, RQ_PUSH, RQ_RET, RQ_SUB_I32, RQ_XOR_RR,
    RQ_PLACE
  } req_kind_t;

  typedef enum logic [1:0] {KIND_NONE, KIND_PLAIN, KIND_JUMP, KIND_PLACE} enc_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_JREL, ST_EMIT, ST_ERR, ST_SCAN, ST_TAKE
  } state_t;

  typedef struct packed {
    logic [4:0]  req_type;
    logic [2:0]  dst_reg;
    logic [2:0]  src_reg;
    logic [63:0] immediate;
    logic [5:0]  label_id;
  } in_req_t;

  typedef struct packed {
    logic        is_patch;
    logic [19:0] address;
    logic [31:0] data;
    logic [1:0]  error;
    logic        last;
  } out_res_t;

  // controller -> datapath
  typedef struct packed {
    logic       capture;
    logic       decode;
    logic       place_wr;
    logic       fix_wr;
    logic       rel_ins;
    logic       emit_byte;
    logic       commit;
    logic       scan_start;
    logic       scan_step;
    logic       take;
    logic       out_err;
    logic       out_patch;
    logic       patch_last;
    logic [1:0] err_code;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic      out_free;
    enc_kind_t kind;
    logic      no_space;
    logic      placed;
    logic      fix_full;
    logic      emit_done;
    logic      scan_end;
    logic      best_found;
    logic      pend_valid;
  } sts_t;

endpackage

// ----- src/xce_ctrl.sv -----
// Controller state machine: sequences decode, byte emission, errors and fixup resolution.
module xce_ctrl import xce_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] err_r, err_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      err_r   <= ERR_OK;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    cmd       = '0;
    cmd.err_code = err_r;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        case (sts.kind)
          KIND_NONE: state_nxt = ST_IDLE;
          KIND_PLACE: begin
            if (sts.placed) begin
              err_nxt   = ERR_PLACED;
              state_nxt = ST_ERR;
            end else begin
              cmd.place_wr   = 1'b1;
              cmd.scan_start = 1'b1;
              state_nxt      = ST_SCAN;
            end
          end
          KIND_JUMP: begin
            if (sts.no_space) begin
              err_nxt   = ERR_SPACE;
              state_nxt = ST_ERR;
            end else if (sts.placed) begin
              state_nxt = ST_JREL;
            end else if (sts.fix_full) begin
              err_nxt   = ERR_FIXUP;
              state_nxt = ST_ERR;
            end else begin
              cmd.fix_wr = 1'b1;
              state_nxt  = ST_EMIT;
            end
          end
          default: begin
            if (sts.no_space) begin
              err_nxt   = ERR_SPACE;
              state_nxt = ST_ERR;
            end else begin
              state_nxt = ST_EMIT;
            end
          end
        endcase
      end
      ST_JREL: begin
        cmd.rel_ins = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_byte = 1'b1;
          if (sts.emit_done) begin
            cmd.commit = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (sts.out_free) begin
          cmd.out_err = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_end) state_nxt = ST_TAKE;
      end
      ST_TAKE: begin
        // hold one patch back so the final one can carry last
        if (sts.best_found) begin
          if (!sts.pend_valid || sts.out_free) begin
            cmd.out_patch  = sts.pend_valid;
            cmd.take       = 1'b1;
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end else if (!sts.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.out_patch  = 1'b1;
          cmd.patch_last = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_jrel_after_decode: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_JREL |-> $past(state_r) == ST_DECODE)
    else $error("rel32 insert not preceded by decode");

  a_take_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TAKE |-> $past(state_r) == ST_SCAN || $past(state_r) == ST_TAKE)
    else $error("fixup take without a completed scan");

endmodule

// ----- src/xce_dp.sv -----
// Datapath: encoder, byte buffer, code offset, label store, fixup store, result register.
module xce_dp import xce_pkg::*; #(
  parameter int CODE_BYTES  = CODE_BYTES_DEF,
  parameter int LABEL_COUNT = LABEL_COUNT_DEF,
  parameter int FIXUP_SLOTS = FIXUP_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_req_t  in_data,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data,
  input  logic     out_stall,
  output logic     out_valid,
  output out_res_t out_data,
  input  cmd_t     cmd,
  output sts_t     sts
);

  // only 64 label ids can reach the store
  localparam int LUSED = (LABEL_COUNT < 64) ? LABEL_COUNT : 64;
  localparam int LIW   = (LUSED > 1) ? $clog2(LUSED) : 1;
  localparam int FSW   = (FIXUP_SLOTS > 1) ? $clog2(FIXUP_SLOTS) : 1;

  in_req_t              req_r;
  logic                 long_mode_r;
  logic [ADDR_W-1:0]    code_offset_r;
  logic [7:0]           buf_r [BUF_LEN];
  logic [3:0]           n_r;
  logic [3:0]           i_r;

  logic                 placed_r [LUSED];
  logic [ADDR_W-1:0]    laddr_mem [LUSED];
  logic [ADDR_W-1:0]    laddr_q;

  logic                 fvalid_r [FIXUP_SLOTS];
  logic [LIW-1:0]       flab_r   [FIXUP_SLOTS];
  logic [ADDR_W-1:0]    floc_r   [FIXUP_SLOTS];

  logic [FSW-1:0]       scan_r;
  logic                 best_found_r;
  logic [FSW-1:0]       best_idx_r;
  logic [ADDR_W-1:0]    best_loc_r;
  logic                 pend_valid_r;
  logic [ADDR_W-1:0]    pend_loc_r;

  logic                 out_valid_r;
  out_res_t             out_res_r;

  // label id reduced modulo the label count by shifted compare-subtract
  logic [16:0]          lab_v;
  logic [LIW-1:0]       lab;
  always_comb begin
    lab_v = {11'b0, req_r.label_id};
    for (int k = 5; k >= 0; k--) begin
      if (lab_v >= (17'(LABEL_COUNT) << k)) lab_v = lab_v - (17'(LABEL_COUNT) << k);
    end
    lab = lab_v[LIW-1:0];
  end

  // instruction encoder
  logic [7:0] bb [BUF_LEN];
  logic [7:0] b  [BUF_LEN];
  logic [3:0] nb, n_enc;
  logic       rexf;
  enc_kind_t  kind;
  logic [7:0] d8, s8, sop, ext;
  logic [63:0] imm;
  always_comb begin
    for (int k = 0; k < BUF_LEN; k++) bb[k] = 8'h00;
    nb   = 4'd0;
    rexf = 1'b0;
    kind = KIND_PLAIN;
    imm  = req_r.immediate;
    d8   = {5'b0, req_r.dst_reg};
    s8   = {5'b0, req_r.src_reg};
    sop  = OP_ADD_ACC;
    ext  = EXT_ADD;
    case (req_r.req_type)
      RQ_ADD_M8: begin
        bb[0] = OP_ALU_I8; bb[1] = d8; bb[2] = imm[7:0]; nb = 4'd3;
      end
      RQ_CMP_M8: begin
        bb[0] = OP_ALU_I8; bb[1] = MODRM_CMP8 | d8; bb[2] = imm[7:0]; nb = 4'd3;
      end
      RQ_ADD_I32, RQ_AND_I32, RQ_CMP_I32, RQ_SUB_I32: begin
        rexf = 1'b1;
        if (req_r.req_type == RQ_AND_I32) begin
          sop = OP_AND_ACC; ext = EXT_AND;
        end else if (req_r.req_type == RQ_CMP_I32) begin
          sop = OP_CMP_ACC; ext = EXT_CMP;
        end else if (req_r.req_type == RQ_SUB_I32) begin
          sop = OP_SUB_ACC; ext = EXT_SUB;
        end
        if (req_r.dst_reg == 3'd0) begin
          bb[0] = sop;
          for (int k = 0; k < 4; k++) bb[k+1] = imm[8*k +: 8];
          nb = 4'd5;
        end else begin
          bb[0] = OP_ALU_I32; bb[1] = ext | d8;
          for (int k = 0; k < 4; k++) bb[k+2] = imm[8*k +: 8];
          nb = 4'd6;
        end
      end
      RQ_CALL: begin
        rexf  = 1'b1;
        bb[0] = OP_MOV_IMM;
        if (long_mode_r) begin
          for (int k = 0; k < 8; k++) bb[k+1] = imm[8*k +: 8];
          bb[9] = OP_GRP5; bb[10] = MODRM_CALL; nb = 4'd11;
        end else begin
          for (int k = 0; k < 4; k++) bb[k+1] = imm[8*k +: 8];
          bb[5] = OP_GRP5; bb[6] = MODRM_CALL; nb = 4'd7;
        end
      end
      RQ_MOV_IMM: begin
        rexf  = 1'b1;
        bb[0] = OP_MOV_IMM + d8;
        if (long_mode_r) begin
          for (int k = 0; k < 8; k++) bb[k+1] = imm[8*k +: 8];
          nb = 4'd9;
        end else begin
          for (int k = 0; k < 4; k++) bb[k+1] = imm[8*k +: 8];
          nb = 4'd5;
        end
      end
      RQ_CMP_RR: begin
        rexf = 1'b1; bb[0] = OP_CMP_RR; bb[1] = MODRM_REG | (s8 << 3) | d8; nb = 4'd2;
      end
      RQ_MOV_RR: begin
        rexf = 1'b1; bb[0] = OP_MOV_RR; bb[1] = MODRM_REG | (d8 << 3) | s8; nb = 4'd2;
      end
      RQ_XOR_RR: begin
        rexf = 1'b1; bb[0] = OP_XOR_RR; bb[1] = MODRM_REG | (d8 << 3) | s8; nb = 4'd2;
      end
      RQ_JE, RQ_JLE, RQ_JNE: begin
        kind  = KIND_JUMP;
        bb[0] = OP_ESC;
        bb[1] = (req_r.req_type == RQ_JE) ? CC_JE :
                (req_r.req_type == RQ_JLE) ? CC_JLE : CC_JNE;
        nb    = 4'd6;
      end
      RQ_JMP: begin
        kind = KIND_JUMP; bb[0] = OP_JMP; nb = 4'd5;
      end
      RQ_LEAVE: begin
        bb[0] = OP_LEAVE; nb = 4'd1;
      end
      RQ_MOV_LD8: begin
        bb[0] = OP_MOV_LD8; bb[1] = (d8 << 3) | s8; nb = 4'd2;
      end
      RQ_MOV_ST8: begin
        bb[0] = OP_MOV_ST8; bb[1] = (s8 << 3) | d8; nb = 4'd2;
      end
      RQ_MOV_ST32: begin
        bb[0] = OP_MOV_ST32; bb[1] = (s8 << 3) | d8; nb = 4'd2;
        // base of stack pointer needs a SIB byte
        if (req_r.dst_reg == 3'd4) begin
          bb[2] = SIB_ESP; nb = 4'd3;
        end
      end
      RQ_POP: begin
        bb[0] = OP_POP + d8; nb = 4'd1;
      end
      RQ_PUSH: begin
        bb[0] = OP_PUSH + d8; nb = 4'd1;
      end
      RQ_RET: begin
        bb[0] = OP_RET; nb = 4'd1;
      end
      RQ_PLACE: kind = KIND_PLACE;
      default:  kind = KIND_NONE;
    endcase
    // optional REX.W prefix shifts the body by one byte
    if (rexf && long_mode_r) begin
      b[0] = OP_REX_W;
      for (int k = 1; k < BUF_LEN; k++) b[k] = bb[k-1];
      n_enc = nb + 4'd1;
    end else begin
      for (int k = 0; k < BUF_LEN; k++) b[k] = bb[k];
      n_enc = nb;
    end
  end

  // first free fixup slot
  logic           free_found;
  logic [FSW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = FIXUP_SLOTS - 1; k >= 0; k--) begin
      if (!fvalid_r[k]) begin
        free_found = 1'b1;
        free_idx   = FSW'(k);
      end
    end
  end

  logic [ADDR_W:0]  space_sum;
  logic [31:0]      rel_disp;
  logic [3:0]       rel_base;
  logic [ADDR_W-1:0] scan_loc;
  logic             scan_hit;
  assign space_sum = {1'b0, code_offset_r} + (ADDR_W+1)'(n_enc);
  assign rel_disp  = 32'(laddr_q) - 32'(code_offset_r + ADDR_W'(n_r));
  assign rel_base  = n_r - 4'd4;
  assign scan_loc  = floc_r[scan_r];
  assign scan_hit  = fvalid_r[scan_r] && (flab_r[scan_r] == lab) &&
                     (!best_found_r || (scan_loc > best_loc_r));

  // status to controller
  always_comb begin
    sts.out_free   = !out_valid_r || !out_stall;
    sts.kind       = kind;
    sts.no_space   = space_sum >= (ADDR_W+1)'(CODE_BYTES);
    sts.placed     = placed_r[lab];
    sts.fix_full   = !free_found;
    sts.emit_done  = i_r == (n_r - 4'd1);
    sts.scan_end   = scan_r == FSW'(FIXUP_SLOTS - 1);
    sts.best_found = best_found_r;
    sts.pend_valid = pend_valid_r;
  end

  // request capture, byte buffer, emit counter
  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_data;
    if (cmd.decode) begin
      for (int k = 0; k < BUF_LEN; k++) buf_r[k] <= b[k];
      n_r <= n_enc;
      i_r <= 4'd0;
    end
    if (cmd.rel_ins) begin
      for (int k = 0; k < 4; k++) buf_r[rel_base + 4'(k)] <= rel_disp[8*k +: 8];
    end
    if (cmd.emit_byte) i_r <= i_r + 4'd1;
  end

  // config register and code offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_mode_r   <= 1'b1;
      code_offset_r <= '0;
    end else begin
      if (cfg_wr_en) long_mode_r <= cfg_wr_data;
      if (cmd.commit) code_offset_r <= code_offset_r + ADDR_W'(n_r);
    end
  end

  // label store: placed marks in flops, addresses in memory with registered read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LUSED; k++) placed_r[k] <= 1'b0;
    end else if (cmd.place_wr) begin
      placed_r[lab] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.place_wr) laddr_mem[lab] <= code_offset_r;
    laddr_q <= laddr_mem[lab];
  end

  // fixup store and newest-first scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < FIXUP_SLOTS; k++) fvalid_r[k] <= 1'b0;
      pend_valid_r <= 1'b0;
      best_found_r <= 1'b0;
    end else begin
      if (cmd.fix_wr) fvalid_r[free_idx] <= 1'b1;
      if (cmd.take) begin
        fvalid_r[best_idx_r] <= 1'b0;
        pend_valid_r         <= 1'b1;
      end else if (cmd.out_patch) begin
        pend_valid_r <= 1'b0;
      end
      if (cmd.scan_start) best_found_r <= 1'b0;
      else if (cmd.scan_step && scan_hit) best_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fix_wr) begin
      flab_r[free_idx] <= lab;
      floc_r[free_idx] <= code_offset_r + ADDR_W'(n_enc) - ADDR_W'(4);
    end
    if (cmd.take) pend_loc_r <= best_loc_r;
    if (cmd.scan_start) scan_r <= '0;
    else if (cmd.scan_step) scan_r <= scan_r + FSW'(1);
    if (cmd.scan_step && scan_hit) begin
      best_idx_r <= scan_r;
      best_loc_r <= scan_loc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_byte || cmd.out_err || cmd.out_patch) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_byte) begin
      out_res_r.is_patch <= 1'b0;
      out_res_r.address  <= code_offset_r + ADDR_W'(i_r);
      out_res_r.data     <= {24'b0, buf_r[i_r]};
      out_res_r.error    <= ERR_OK;
      out_res_r.last     <= i_r == (n_r - 4'd1);
    end else if (cmd.out_err) begin
      out_res_r.is_patch <= 1'b0;
      out_res_r.address  <= code_offset_r;
      out_res_r.data     <= '0;
      out_res_r.error    <= cmd.err_code;
      out_res_r.last     <= 1'b1;
    end else if (cmd.out_patch) begin
      out_res_r.is_patch <= 1'b1;
      out_res_r.address  <= pend_loc_r;
      out_res_r.data     <= 32'(code_offset_r) - 32'(pend_loc_r + ADDR_W'(4));
      out_res_r.error    <= ERR_OK;
      out_res_r.last     <= cmd.patch_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_res_r;

  a_patch_behind_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.is_patch |->
      ({1'b0, out_res_r.address} + (ADDR_W+1)'(4)) <= {1'b0, code_offset_r})
    else $error("patch field not behind code offset");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.emit_byte, cmd.out_err, cmd.out_patch}) <= 1)
    else $error("more than one result loaded in a cycle");

endmodule

// ----- src/x86_code_emitter_with_fixups.sv -----
// A taken request is captured, then decoded into the byte buffer; a jump to a placed label
// then has its rel32 field inserted. Code bytes go to the result register one per cycle while
// the receiver does not stall. Label placement scans the fixup store once per pending fixup
// plus one final empty scan.
// Reset (synchronous, rst_n low): offset 0, labels unplaced, fixups free, long_mode 1.
// No clearing pass; a request may be taken in the first cycle after reset.
module x86_code_emitter_with_fixups import xce_pkg::*; #(
  parameter int CODE_BYTES  = CODE_BYTES_DEF,
  parameter int LABEL_COUNT = LABEL_COUNT_DEF,
  parameter int FIXUP_SLOTS = FIXUP_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_data,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  xce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // encoder, stores and result register
  xce_dp #(
    .CODE_BYTES  (CODE_BYTES),
    .LABEL_COUNT (LABEL_COUNT),
    .FIXUP_SLOTS (FIXUP_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// ----- tb/x86_code_emitter_with_fixups_test.sv -----
// Testbench for the x86 code emitter: directed and random requests checked against a byte-level predictor.
`timescale 1ns / 1ps

module x86_code_emitter_with_fixups_test;
  import xce_pkg::*;

  localparam int  LIMIT_CYCLES = 4000000;
  localparam int  SETTLE       = 1200;   // covers a full fixup scan after the last result
  localparam int  HOLD_CYCLES  = 400;

  // Predicts the byte and patch stream and checks what the block emits
  class emit_scoreboard;
    bit              long_mode = 1'b1;
    bit [19:0]       offset;
    bit              placed [LABEL_COUNT_DEF];
    bit [19:0]       label_at [LABEL_COUNT_DEF];
    bit              fix_used [FIXUP_SLOTS_DEF];
    bit [5:0]        fix_label [FIXUP_SLOTS_DEF];
    bit [19:0]       fix_loc [FIXUP_SLOTS_DEF];
    out_res_t        expected_q[$];
    int              errors;

    function void push(bit patch, bit [19:0] addr, bit [31:0] data, bit [1:0] err, bit lst);
      out_res_t r;
      r.is_patch = patch;
      r.address  = addr;
      r.data     = data;
      r.error    = err;
      r.last     = lst;
      expected_q.push_back(r);
    endfunction

    function void put_le(ref bit [7:0] b[$], input bit [63:0] v, input int cnt);
      for (int i = 0; i < cnt; i++) b.push_back(v[8*i +: 8]);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Work out the results of one accepted request
    function void note_request(in_req_t rq);
      bit [7:0]  b[$];
      int        rel_at;
      int        slot;
      int        best;
      int        k;
      bit [5:0]  lab;
      bit [31:0] field;
      bit [31:0] disp;
      lab    = rq.label_id;
      rel_at = -1;
      if (rq.req_type == RQ_PLACE) begin
        if (placed[lab]) begin
          push(1'b0, offset, 32'd0, ERR_PLACED, 1'b1);
          return;
        end
        placed[lab]   = 1'b1;
        label_at[lab] = offset;
        k = 0;
        // newest fixup first
        forever begin
          best = -1;
          for (int i = 0; i < FIXUP_SLOTS_DEF; i++)
            if (fix_used[i] && fix_label[i] == lab &&
                (best < 0 || fix_loc[i] > fix_loc[best])) best = i;
          if (best < 0 || k >= 32) break;
          push(1'b1, fix_loc[best], {12'd0, offset} - ({12'd0, fix_loc[best]} + 32'd4),
               ERR_OK, 1'b0);
          fix_used[best] = 1'b0;
          k++;
        end
        if (k > 0) expected_q[$].last = 1'b1;
        return;
      end
      case (rq.req_type)
        RQ_ADD_M8: begin
          b.push_back(OP_ALU_I8); b.push_back({5'd0, rq.dst_reg}); put_le(b, rq.immediate, 1);
        end
        RQ_CMP_M8: begin
          b.push_back(OP_ALU_I8); b.push_back(MODRM_CMP8 | rq.dst_reg);
          put_le(b, rq.immediate, 1);
        end
        RQ_ADD_I32, RQ_AND_I32, RQ_CMP_I32, RQ_SUB_I32: begin
          bit [7:0] sop, ext;
          case (rq.req_type)
            RQ_ADD_I32: begin sop = OP_ADD_ACC; ext = EXT_ADD; end
            RQ_AND_I32: begin sop = OP_AND_ACC; ext = EXT_AND; end
            RQ_CMP_I32: begin sop = OP_CMP_ACC; ext = EXT_CMP; end
            default:    begin sop = OP_SUB_ACC; ext = EXT_SUB; end
          endcase
          if (long_mode) b.push_back(OP_REX_W);
          if (rq.dst_reg == 0) b.push_back(sop);
          else begin
            b.push_back(OP_ALU_I32); b.push_back(ext | rq.dst_reg);
          end
          put_le(b, rq.immediate, 4);
        end
        RQ_CALL: begin
          if (long_mode) b.push_back(OP_REX_W);
          b.push_back(OP_MOV_IMM);
          put_le(b, rq.immediate, long_mode ? 8 : 4);
          b.push_back(OP_GRP5); b.push_back(MODRM_CALL);
        end
        RQ_MOV_IMM: begin
          if (long_mode) b.push_back(OP_REX_W);
          b.push_back(OP_MOV_IMM + rq.dst_reg);
          put_le(b, rq.immediate, long_mode ? 8 : 4);
        end
        RQ_CMP_RR: begin
          if (long_mode) b.push_back(OP_REX_W);
          b.push_back(OP_CMP_RR); b.push_back({2'b11, rq.src_reg, rq.dst_reg});
        end
        RQ_MOV_RR: begin
          if (long_mode) b.push_back(OP_REX_W);
          b.push_back(OP_MOV_RR); b.push_back({2'b11, rq.dst_reg, rq.src_reg});
        end
        RQ_XOR_RR: begin
          if (long_mode) b.push_back(OP_REX_W);
          b.push_back(OP_XOR_RR); b.push_back({2'b11, rq.dst_reg, rq.src_reg});
        end
        RQ_JE, RQ_JLE, RQ_JNE: begin
          b.push_back(OP_ESC);
          b.push_back(rq.req_type == RQ_JE ? CC_JE : (rq.req_type == RQ_JLE ? CC_JLE : CC_JNE));
          rel_at = b.size();
        end
        RQ_JMP: begin
          b.push_back(OP_JMP);
          rel_at = b.size();
        end
        RQ_LEAVE:    b.push_back(OP_LEAVE);
        RQ_MOV_LD8: begin
          b.push_back(OP_MOV_LD8); b.push_back({2'b00, rq.dst_reg, rq.src_reg});
        end
        RQ_MOV_ST8: begin
          b.push_back(OP_MOV_ST8); b.push_back({2'b00, rq.src_reg, rq.dst_reg});
        end
        RQ_MOV_ST32: begin
          b.push_back(OP_MOV_ST32); b.push_back({2'b00, rq.src_reg, rq.dst_reg});
          if (rq.dst_reg == 4) b.push_back(SIB_ESP);
        end
        RQ_POP:  b.push_back(OP_POP + rq.dst_reg);
        RQ_PUSH: b.push_back(OP_PUSH + rq.dst_reg);
        RQ_RET:  b.push_back(OP_RET);
        default: return;  // unused request codes are dropped
      endcase
      // jumps carry a 4-byte displacement field
      if (rel_at >= 0) put_le(b, 64'd0, 4);
      if ({12'd0, offset} + b.size() >= CODE_BYTES_DEF) begin
        push(1'b0, offset, 32'd0, ERR_SPACE, 1'b1);
        return;
      end
      if (rel_at >= 0) begin
        field = {12'd0, offset} + rel_at;
        if (placed[lab]) begin
          disp = {12'd0, label_at[lab]} - (field + 32'd4);
          for (int i = 0; i < 4; i++) b[rel_at + i] = disp[8*i +: 8];
        end else begin
          slot = -1;
          for (int i = 0; i < FIXUP_SLOTS_DEF; i++)
            if (!fix_used[i]) begin
              slot = i;
              break;
            end
          if (slot < 0) begin
            push(1'b0, offset, 32'd0, ERR_FIXUP, 1'b1);
            return;
          end
          fix_used[slot]  = 1'b1;
          fix_label[slot] = lab;
          fix_loc[slot]   = field[19:0];
        end
      end
      foreach (b[i]) push(1'b0, offset + 20'(i), {24'd0, b[i]}, ERR_OK, i == b.size() - 1);
      offset = offset + 20'(b.size());
    endfunction

    task report(string what, out_res_t got, out_res_t exp_r);
      errors++;
      $display("mismatch %s: got p%0d a%05h d%08h e%0d l%0d, want p%0d a%05h d%08h e%0d l%0d",
               what, got.is_patch, got.address, got.data, got.error, got.last,
               exp_r.is_patch, exp_r.address, exp_r.data, exp_r.error, exp_r.last);
    endtask

    task check_result(out_res_t got);
      out_res_t exp_r;
      if (expected_q.size() == 0) begin
        report("unexpected", got, '0);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.is_patch != exp_r.is_patch) report("is_patch", got, exp_r);
      if (got.address != exp_r.address)   report("address", got, exp_r);
      if (got.data != exp_r.data)         report("data", got, exp_r);
      if (got.error != exp_r.error)       report("error", got, exp_r);
      if (got.last != exp_r.last)         report("last", got, exp_r);
    endtask
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  out_res_t out_data;
  logic     cfg_wr_en;
  logic     cfg_wr_data;

  emit_scoreboard sb;
  bit  quiet;
  bit  hold_req;
  int  cycles;

  x86_code_emitter_with_fixups dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if ($urandom_range(0, 11) == 0) begin
        burst = $urandom_range(1, 14) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task send_request(in_req_t rq);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (in_stall);
    sb.note_request(rq);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_mode(bit mode);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.long_mode = mode;
  endtask

  function in_req_t make_request(bit [4:0] kind, bit [2:0] dst, bit [2:0] src,
                                 bit [63:0] imm, bit [5:0] lab);
    in_req_t rq;
    rq.req_type  = kind;
    rq.dst_reg   = dst;
    rq.src_reg   = src;
    rq.immediate = imm;
    rq.label_id  = lab;
    return rq;
  endfunction

  // Mostly code with jumps and sparse label placements; some unused codes
  function in_req_t random_request();
    int        pick;
    bit [4:0]  kind;
    bit [63:0] imm;
    pick = $urandom_range(0, 99);
    if (pick < 6)       kind = RQ_PLACE;
    else if (pick < 30) kind = 5'($urandom_range(RQ_JE, RQ_JNE));
    else if (pick < 34) kind = 5'($urandom_range(23, 31));
    else                kind = 5'($urandom_range(0, 21));
    case ($urandom_range(0, 7))
      0:       imm = '0;
      1:       imm = '1;
      default: imm = {$urandom, $urandom};
    endcase
    return make_request(kind, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), imm,
                        6'($urandom_range(0, 63)));
  endfunction

  task random_phase(int count);
    for (int i = 0; i < count; i++) send_request(random_request());
  endtask

  initial begin
    sb = new();
    quiet     = 1'b0;
    hold_req  = 1'b0;
    cycles    = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: every non-place kind once, jumps to an unplaced label, then resolve it
    for (int k = 0; k < 22; k++)
      send_request(make_request(5'(k), 3'(k % 8), 3'(7 - (k % 8)), (k % 2) ? '1 : '0,
                                6'd5));
    send_request(make_request(RQ_ADD_I32, 3'd0, 3'd7, 64'h8000_0001_7FFF_FFFF, 6'd0));
    send_request(make_request(RQ_MOV_ST32, 3'd4, 3'd7, '0, 6'd0));
    send_request(make_request(RQ_PLACE, 3'd0, 3'd0, '0, 6'd5));
    send_request(make_request(RQ_JMP, 3'd0, 3'd0, '0, 6'd5));
    send_request(make_request(RQ_PLACE, 3'd7, 3'd7, '1, 6'd5));
    send_request(make_request(5'd31, 3'd7, 3'd7, '1, 6'd63));
    drain();

    // 32-bit forms, with a long receiver hold-off early on
    write_mode(1'b0);
    hold_req = 1'b1;
    random_phase(200);
    drain();

    write_mode(1'b1);
    random_phase(200);
    drain();

    // closing stretch without idling
    write_mode(1'b0);
    quiet = 1'b1;
    random_phase(100);
    drain();

    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/xce_pkg.sv
src/xce_ctrl.sv
src/xce_dp.sv
src/x86_code_emitter_with_fixups.sv
tb/x86_code_emitter_with_fixups_test.sv
